// File: rtl/mlfd_pkg.sv
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants of the magic/length frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfd_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int POS_W        = 7;
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 32;
    localparam int TDATA_W      = 160;

    typedef logic [1:0] disc_op_t;
    localparam disc_op_t DISC_NONE = 2'd0;
    localparam disc_op_t DISC_ONE  = 2'd1;
    localparam disc_op_t DISC_TWO  = 2'd2;
    localparam disc_op_t DISC_HDR  = 2'd3;

    typedef logic [1:0] pos_op_t;
    localparam pos_op_t POS_HOLD = 2'd0;
    localparam pos_op_t POS_INC  = 2'd1;
    localparam pos_op_t POS_CLR  = 2'd2;

    typedef struct packed {
        pos_op_t  pos_op;
        disc_op_t disc_op;
        logic     rej_inc;
        logic     hdr_wr;
        logic     pay_wr;
        logic     run_clr;
        logic     run_inc;
        logic     load_out;
        logic     acc_inc;
    } mlfd_cmd_t;

    typedef struct packed {
        logic pos_zero;
        logic pos_one;
        logic in_hdr;
        logic hdr_end;
        logic pay_end;
        logic match1;
        logic match2;
        logic len_over;
        logic len_zero_new;
        logic run_last;
        logic out_free;
    } mlfd_stat_t;

endpackage

`default_nettype wire

// File: rtl/mlfd_ctrl.sv
// ----------------------------------------------------------------------------
// mlfd_ctrl
// Controller: decides what each received byte does and sequences the
// readout of a stored frame, a payload memory read then an output load per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mlfd_pkg::mlfd_stat_t stat,
    output mlfd_pkg::mlfd_cmd_t     cmd
);
    import mlfd_pkg::*;

    localparam logic [1:0] ST_RECV = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.pos_op  = POS_HOLD;
        cmd.disc_op = DISC_NONE;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_RECV:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    priority if (stat.pos_zero)
                    begin
                        if (stat.match1)
                            cmd.pos_op = POS_INC;
                        else
                            cmd.disc_op = DISC_ONE;
                    end
                    else if (stat.pos_one)
                    begin
                        // second magic wins when both magics are equal
                        priority if (stat.match2)
                            cmd.pos_op = POS_INC;
                        else if (stat.match1)
                            cmd.disc_op = DISC_ONE;
                        else
                        begin
                            cmd.disc_op = DISC_TWO;
                            cmd.pos_op  = POS_CLR;
                        end
                    end
                    else if (stat.in_hdr)
                    begin
                        cmd.hdr_wr = 1'b1;
                        priority if (stat.hdr_end && stat.len_over)
                        begin
                            cmd.rej_inc = 1'b1;
                            cmd.disc_op = DISC_HDR;
                            cmd.pos_op  = POS_CLR;
                        end
                        else if (stat.hdr_end && stat.len_zero_new)
                        begin
                            cmd.pos_op  = POS_CLR;
                            cmd.run_clr = 1'b1;
                            state_next  = ST_READ;
                        end
                        else
                            cmd.pos_op = POS_INC;
                    end
                    else
                    begin
                        cmd.pay_wr = 1'b1;
                        if (stat.pay_end)
                        begin
                            cmd.pos_op  = POS_CLR;
                            cmd.run_clr = 1'b1;
                            state_next  = ST_READ;
                        end
                        else
                            cmd.pos_op = POS_INC;
                    end
                end
            end
            ST_READ:
            begin
                // payload memory read data lands in the next cycle
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (stat.run_last)
                    begin
                        cmd.acc_inc = 1'b1;
                        state_next  = ST_RECV;
                    end
                    else
                    begin
                        cmd.run_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mlfd_dp.sv
// ----------------------------------------------------------------------------
// mlfd_dp
// Datapath: magic registers, byte position, header and payload stores,
// wrapping counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfd_dp #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [mlfd_pkg::BYTE_W-1:0]        cfg_data,
    input  wire logic [mlfd_pkg::BYTE_W-1:0]        rx_byte,
    input  wire mlfd_pkg::mlfd_cmd_t                cmd,
    output mlfd_pkg::mlfd_stat_t                    stat,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [mlfd_pkg::TDATA_W-1:0]            out_data,
    output logic                                    out_last
);
    import mlfd_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic CFG_FIRST  = 1'b0;
    localparam logic CFG_SECOND = 1'b1;

    logic [BYTE_W-1:0] first_magic_reg;
    logic [BYTE_W-1:0] second_magic_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] hdr_reg [8];
    logic [BYTE_W-1:0] pay_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [AW-1:0]     run_idx_reg;
    logic [CNT_W-1:0]  acc_cnt_reg;
    logic [CNT_W-1:0]  rej_cnt_reg;
    logic [CNT_W-1:0]  disc_cnt_reg;
    logic [CNT_W-1:0]  disc_add;
    logic              out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [15:0]       len_new;
    logic [POS_W-1:0]  len7;
    logic [POS_W-1:0]  pay_off;
    logic [2:0]        hdr_idx;
    logic              run_last;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_magic_reg  <= 8'd165;
            second_magic_reg <= 8'd90;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST:  first_magic_reg  <= cfg_data;
                CFG_SECOND: second_magic_reg <= cfg_data;
                default:    first_magic_reg  <= first_magic_reg;
            endcase
        end
    end

    assign len_new  = {rx_byte, hdr_reg[6]};
    assign len7     = hdr_reg[6][POS_W-1:0];
    assign pay_off  = pos_reg - POS_W'(HEADER_BYTES);
    assign hdr_idx  = 3'(pos_reg - 7'd2);
    assign run_last = (len7 == '0) || ((POS_W'(run_idx_reg) + 7'd1) == len7);

    always_comb
    begin
        stat.pos_zero     = (pos_reg == 7'd0);
        stat.pos_one      = (pos_reg == 7'd1);
        stat.in_hdr       = (pos_reg < POS_W'(HEADER_BYTES));
        stat.hdr_end      = (pos_reg == POS_W'(HEADER_BYTES - 1));
        stat.pay_end      = ((pay_off + 7'd1) == len7);
        stat.match1       = (rx_byte == first_magic_reg);
        stat.match2       = (rx_byte == second_magic_reg);
        stat.len_over     = (len_new > 16'(MAX_PAYLOAD));
        stat.len_zero_new = (len_new == 16'd0);
        stat.run_last     = run_last;
        stat.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        unique case (cmd.pos_op)
            POS_INC: pos_next = pos_reg + 7'd1;
            POS_CLR: pos_next = '0;
            default: pos_next = pos_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.disc_op)
            DISC_ONE: disc_add = 32'd1;
            DISC_TWO: disc_add = 32'd2;
            DISC_HDR: disc_add = CNT_W'(HEADER_BYTES);
            default:  disc_add = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            run_idx_reg   <= '0;
            acc_cnt_reg   <= '0;
            rej_cnt_reg   <= '0;
            disc_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            disc_cnt_reg <= disc_cnt_reg + disc_add;
            if (cmd.rej_inc)
                rej_cnt_reg <= rej_cnt_reg + 32'd1;
            if (cmd.acc_inc)
                acc_cnt_reg <= acc_cnt_reg + 32'd1;
            if (cmd.run_clr)
                run_idx_reg <= '0;
            else if (cmd.run_inc)
                run_idx_reg <= run_idx_reg + AW'(1);
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // header and payload stores, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_wr)
            hdr_reg[hdr_idx] <= rx_byte;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pay_wr)
            pay_mem[pay_off[AW-1:0]] <= rx_byte;
        rd_data_reg <= pay_mem[run_idx_reg];
    end

    // output register: counter snapshots are stable for the whole run
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {1'b0,
                             disc_cnt_reg,
                             rej_cnt_reg,
                             acc_cnt_reg,
                             (len7 == '0) ? 8'd0 : rd_data_reg,
                             len7,
                             hdr_reg[5], hdr_reg[4],
                             hdr_reg[3], hdr_reg[2],
                             hdr_reg[1], hdr_reg[0]};
            out_last_reg <= run_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/magic_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// magic_length_frame_deframer
// Hunts for two magic bytes, collects a ten-byte header and a length-prefixed
// payload, and emits each good frame as a run of beats.
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one received link byte per beat. m_* carries one beat per
//   payload byte (one beat for an empty payload); m_tlast marks the last
//   beat of a frame. cfg_we/cfg_index/cfg_data set the two magic values.
//   a byte is taken whenever s_tvalid is high while the block is receiving.
//   the byte that completes a frame starts the readout: each result beat
//   needs a payload memory read, then a load of the output register, and
//   s_tready stays low until the readout of the frame is done. m_tvalid
//   for the first beat rises once the read and load steps have followed
//   the edge that takes the final byte of the frame.
//   the output register lets a new byte be taken while the final beat of
//   the previous frame still waits on m_tready; a stalled receiver holds
//   the readout, and with it s_tready, until the register drains.
//   reset restores the magics to 0xa5 and 0x5a, clears the counters and
//   returns to hunting for the first magic; stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_length_frame_deframer #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [mlfd_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mlfd_pkg::BYTE_W-1:0]    s_tdata,   // rx_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // proto_major[7:0], proto_minor[15:8], frame_type[23:16],
    // frame_flags[31:24], sequence_number[47:32], body_length[54:48],
    // payload_byte[62:55], frames_accepted[94:63], headers_rejected[126:95],
    // bytes_discarded[158:127], zero[159]
    output logic [mlfd_pkg::TDATA_W-1:0]        m_tdata,
    output logic                                m_tlast    // last_of_frame
);
    import mlfd_pkg::*;

    mlfd_cmd_t  cmd;
    mlfd_stat_t stat;

    mlfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlfd_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // a frame-ending byte always starts a readout that blocks input
    a_frame_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.run_clr && s_tvalid && s_tready) |=> !s_tready)
        else $error("input not stalled after frame end");

    // an empty payload is a single-beat run
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[54:48] == 7'd0)) |-> m_tlast)
        else $error("empty frame beat without tlast");

    // only lengths within the limit are delivered
    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[54:48] <= 7'(MAX_PAYLOAD)))
        else $error("delivered payload length above limit");

    // readout never loads a beat while input is being taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !s_tready)
        else $error("output load during receive");

endmodule

`default_nettype wire
